### rtl/rfw_pkg.sv
// Package for the reflection fade weight unit: widths, fixed-point constants,
// register indexes and the ramp classification type. No dependencies.
package rfw_pkg;

	// Widest ramp operand (the Q16.16 depth) and the Q1.16 result width.
	localparam int RAMP_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int Q_W       = FRAC_W + 1;
	localparam int EDGE_W    = Q_W + 1;
	localparam int DIV_STEPS = FRAC_W;
	// Input capture, ramp classification, divider steps and three weight stages.
	localparam int PIPE_DEPTH = DIV_STEPS + 5;

	localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(1) << FRAC_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EDGE_ON    = 3'd0,
		CFG_EDGE_START = 3'd1,
		CFG_EDGE_END   = 3'd2,
		CFG_DIST_ON    = 3'd3,
		CFG_DIST_START = 3'd4,
		CFG_DIST_END   = 3'd5,
		CFG_ROUGH_THR  = 3'd6
	} cfg_idx_t;

	// Outcome of the span checks ahead of the divider.
	typedef enum logic [1:0] {
		RAMP_ONE,
		RAMP_ZERO,
		RAMP_DIV
	} ramp_mode_t;

endpackage

### rtl/rfw_ramp.sv
// One clamped linear ramp factor, 1 - min((v - s) / (e - s), 1), in Q1.16.
// A restoring divider yields one quotient bit per stage. Depends on rfw_pkg.
module rfw_ramp import rfw_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [RAMP_W-1:0] v,
	input  logic [RAMP_W-1:0] s,
	input  logic [RAMP_W-1:0] e,
	output logic [Q_W-1:0]    factor
);

	logic [RAMP_W-1:0] num_c;
	logic [RAMP_W-1:0] den_c;

	ramp_mode_t           mode_s [0:DIV_STEPS];
	logic [RAMP_W-1:0]    rem_s  [0:DIV_STEPS];
	logic [RAMP_W-1:0]    den_s  [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_s  [0:DIV_STEPS];

	assign num_c = v - s;
	assign den_c = e - s;

	// When the offset reaches the span the ramp is clamped, so the divider only
	// ever sees a remainder below the divisor and the quotient fits 16 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			priority if (v <= s) begin
				mode_s[0] <= RAMP_ONE;
			end else if ((e <= s) || (num_c >= den_c)) begin
				mode_s[0] <= RAMP_ZERO;
			end else begin
				mode_s[0] <= RAMP_DIV;
			end
			rem_s[0] <= num_c;
			den_s[0] <= den_c;
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [RAMP_W+1:0] trial;

		assign trial = {1'b0, rem_s[k], 1'b0} - {2'b00, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				mode_s[k+1] <= mode_s[k];
				den_s[k+1]  <= den_s[k];
				if (!trial[RAMP_W+1]) begin
					rem_s[k+1] <= trial[RAMP_W-1:0];
					quo_s[k+1] <= {quo_s[k][DIV_STEPS-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= {rem_s[k][RAMP_W-2:0], 1'b0};
					quo_s[k+1] <= {quo_s[k][DIV_STEPS-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		unique case (mode_s[DIV_STEPS])
			RAMP_ONE:  factor = ONE_Q16;
			RAMP_ZERO: factor = '0;
			RAMP_DIV:  factor = ONE_Q16 - {1'b0, quo_s[DIV_STEPS]};
			default:   factor = '0;
		endcase
	end

endmodule

### rtl/reflection_fade_weight_unit.sv
// Top level of the reflection fade weight unit: configuration registers,
// input stage, three ramp pipelines and the weight multiply chain.
// Depends on rfw_pkg and rfw_ramp.
//
// Usage: one pixel beat enters on the input channel (in_valid/in_ready) with
// its screen position, view depth and roughness, and one fade weight beat
// leaves on the output channel (out_valid/out_ready) for every pixel, in order.
// The weight is the product of the edge, distance and roughness factors, each
// one minus a clamped linear ramp, truncated to Q1.16.
// The pipeline has one input stage, one stage of span checks, sixteen divider
// stages (one quotient bit each, set by the restoring divider in each ramp)
// and three stages for the two multiplies.
// Throughput is one pixel per cycle. The whole pipeline advances together;
// when the receiver holds out_ready low with a beat waiting, the pipeline
// freezes and in_ready drops, so nothing is lost or repeated. Bubbles travel as
// cleared valid bits and are not squeezed out, as the pipeline only holds while
// a finished beat waits at the output.
// Reset clears every valid bit and loads the registers with their defaults.
// Configuration writes act at once and must be made only while idle (unchecked).
module reflection_fade_weight_unit import rfw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [Q_W-1:0]        pos_x,
	input  logic [Q_W-1:0]        pos_y,
	input  logic [RAMP_W-1:0]     view_depth,
	input  logic [Q_W-1:0]        surface_rough,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [Q_W-1:0]        fade_weight,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic              edge_on_q;
	logic [Q_W-1:0]    edge_start_q;
	logic [Q_W-1:0]    edge_end_q;
	logic              dist_on_q;
	logic [RAMP_W-1:0] dist_start_q;
	logic [RAMP_W-1:0] dist_end_q;
	logic [Q_W-1:0]    rough_thr_q;

	logic [PIPE_DEPTH:1] vld_s;
	logic                en;

	logic [EDGE_W-1:0] dx_c, dy_c, ex_c, ey_c;
	logic [EDGE_W-1:0] edge_s1;
	logic [RAMP_W-1:0] depth_s1;
	logic [Q_W-1:0]    rough_s1;

	logic [Q_W-1:0] fe, fd, fr;
	logic [Q_W-1:0] wa_s19, fd_s19, fr_s19;
	logic [Q_W-1:0] wb_s20, fr_s20;
	logic [Q_W-1:0] wc_s21;
	logic [2*Q_W-1:0] prod_b, prod_c;

	// Configuration registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_on_q    <= 1'b1;
			edge_start_q <= Q_W'(52429);
			edge_end_q   <= ONE_Q16;
			dist_on_q    <= 1'b1;
			dist_start_q <= RAMP_W'(3276800);
			dist_end_q   <= RAMP_W'(6553600);
			rough_thr_q  <= Q_W'(32768);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EDGE_ON:    edge_on_q    <= cfg_data[0];
				CFG_EDGE_START: edge_start_q <= cfg_data[Q_W-1:0];
				CFG_EDGE_END:   edge_end_q   <= cfg_data[Q_W-1:0];
				CFG_DIST_ON:    dist_on_q    <= cfg_data[0];
				CFG_DIST_START: dist_start_q <= cfg_data[RAMP_W-1:0];
				CFG_DIST_END:   dist_end_q   <= cfg_data[RAMP_W-1:0];
				CFG_ROUGH_THR:  rough_thr_q  <= cfg_data[Q_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves as one unless a finished beat is held at the output.
	assign en       = !vld_s[PIPE_DEPTH] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_DEPTH-1:1], in_valid};
		end
	end

	// Edge measure: distance of each coordinate from the screen centre, doubled,
	// kept at full width so positions beyond 1.0 simply clamp the ramp.
	assign dx_c = {pos_x, 1'b0};
	assign dy_c = {pos_y, 1'b0};
	assign ex_c = (dx_c >= EDGE_W'(ONE_Q16)) ? dx_c - EDGE_W'(ONE_Q16)
	                                          : EDGE_W'(ONE_Q16) - dx_c;
	assign ey_c = (dy_c >= EDGE_W'(ONE_Q16)) ? dy_c - EDGE_W'(ONE_Q16)
	                                          : EDGE_W'(ONE_Q16) - dy_c;

	always_ff @(posedge clk) begin
		if (en) begin
			edge_s1  <= (ex_c > ey_c) ? ex_c : ey_c;
			depth_s1 <= view_depth;
			rough_s1 <= surface_rough;
		end
	end

	rfw_ramp u_edge (
		.clk    (clk),
		.en     (en),
		.v      (RAMP_W'(edge_s1)),
		.s      (RAMP_W'(edge_start_q)),
		.e      (RAMP_W'(edge_end_q)),
		.factor (fe)
	);

	rfw_ramp u_dist (
		.clk    (clk),
		.en     (en),
		.v      (depth_s1),
		.s      (dist_start_q),
		.e      (dist_end_q),
		.factor (fd)
	);

	rfw_ramp u_rough (
		.clk    (clk),
		.en     (en),
		.v      (RAMP_W'(rough_s1)),
		.s      (RAMP_W'(rough_thr_q)),
		.e      (RAMP_W'(ONE_Q16)),
		.factor (fr)
	);

	// A disabled factor is replaced by 1.0, which leaves the product unchanged
	// under truncation, so the multiply chain never needs bypassing.
	assign prod_b = wa_s19 * fd_s19;
	assign prod_c = wb_s20 * fr_s20;

	always_ff @(posedge clk) begin
		if (en) begin
			wa_s19 <= edge_on_q ? fe : ONE_Q16;
			fd_s19 <= dist_on_q ? fd : ONE_Q16;
			fr_s19 <= fr;
			wb_s20 <= prod_b[FRAC_W+Q_W-1:FRAC_W];
			fr_s20 <= fr_s19;
			wc_s21 <= prod_c[FRAC_W+Q_W-1:FRAC_W];
		end
	end

	assign out_valid   = vld_s[PIPE_DEPTH];
	assign fade_weight = wc_s21;

endmodule

### tb/sv/reflection_fade_weight_unit_tb.sv
// Testbench for the reflection fade weight unit: drives pixel beats with bursty
// gaps, stalls the result channel, and checks each fade weight against a predictor.
// Depends on rfw_pkg and the reflection_fade_weight_unit RTL.
module reflection_fade_weight_unit_tb;
	import rfw_pkg::*;

	// One pixel beat as it is presented on the input channel.
	typedef struct packed {
		logic [Q_W-1:0]    x;
		logic [Q_W-1:0]    y;
		logic [RAMP_W-1:0] depth;
		logic [Q_W-1:0]    rough;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [Q_W-1:0] pos_x = '0;
	logic [Q_W-1:0] pos_y = '0;
	logic [RAMP_W-1:0] view_depth = '0;
	logic [Q_W-1:0] surface_rough = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [Q_W-1:0] fade_weight;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the configuration registers, kept in step with every write.
	logic            sh_edge_on;
	logic [Q_W-1:0]  sh_edge_start;
	logic [Q_W-1:0]  sh_edge_end;
	logic            sh_dist_on;
	logic [31:0]     sh_dist_start;
	logic [31:0]     sh_dist_end;
	logic [Q_W-1:0]  sh_rough_thr;

	pixel_t         pending_pixels[$];
	logic [Q_W-1:0] expected_weights[$];
	int             mismatch_count = 0;
	bit             stim_done = 1'b0;
	bit             in_taken = 1'b0;
	int             gap_left = 0;
	int             burst_left = 0;
	int             stall_phase = 0;
	int             stall_mode = 0;

	reflection_fade_weight_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One minus a clamped ramp; the quotient is worked at 64 bits, as the offset
	// shifted by sixteen can exceed 32 bits for depth.
	function automatic logic [Q_W-1:0] ramp_keep(logic [63:0] v, logic [63:0] s,
			logic [63:0] e);
		logic [63:0] t;
		if (v <= s) return ONE_Q16;
		if (e <= s) return '0;
		t = ((v - s) << 16) / (e - s);
		if (t >= 64'd65536) return '0;
		return Q_W'(64'd65536 - t);
	endfunction

	function automatic logic [63:0] edge_fold(logic [Q_W-1:0] p);
		logic [63:0] d;
		d = 64'(p) * 2;
		return (d >= 64'd65536) ? d - 64'd65536 : 64'd65536 - d;
	endfunction

	function automatic logic [Q_W-1:0] predict_weight(pixel_t px);
		logic [63:0] w;
		logic [63:0] ex;
		logic [63:0] ey;
		w = 64'd65536;
		if (sh_edge_on) begin
			ex = edge_fold(px.x);
			ey = edge_fold(px.y);
			w = (w * ramp_keep((ex > ey) ? ex : ey, sh_edge_start, sh_edge_end)) >> 16;
		end
		if (sh_dist_on)
			w = (w * ramp_keep(px.depth, sh_dist_start, sh_dist_end)) >> 16;
		w = (w * ramp_keep(px.rough, sh_rough_thr, 64'd65536)) >> 16;
		return Q_W'(w);
	endfunction

	task automatic report(string what, logic [Q_W-1:0] got, logic [Q_W-1:0] want);
		$display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Register writes happen only while the pipeline is empty; the shadow copy
	// is updated alongside so the predictor sees the same settings.
	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_EDGE_ON:    sh_edge_on = val[0];
			CFG_EDGE_START: sh_edge_start = val[Q_W-1:0];
			CFG_EDGE_END:   sh_edge_end = val[Q_W-1:0];
			CFG_DIST_ON:    sh_dist_on = val[0];
			CFG_DIST_START: sh_dist_start = val;
			CFG_DIST_END:   sh_dist_end = val;
			CFG_ROUGH_THR:  sh_rough_thr = val[Q_W-1:0];
			default: ;
		endcase
	endtask

	// Wait for the pipeline to drain, then a margin beyond its latency.
	task automatic drain();
		wait (pending_pixels.size() == 0 && expected_weights.size() == 0);
		repeat (PIPE_DEPTH + 4) @(negedge clk);
	endtask

	// Q1.16 values, biased towards the interesting corners and above 1.0.
	function automatic logic [Q_W-1:0] rand_q();
		case ($urandom_range(0, 5))
			0: return Q_W'($urandom_range(0, 3));
			1: return Q_W'($urandom_range(65533, 65536));
			2: return Q_W'($urandom_range(65537, 131071));
			3: return Q_W'($urandom_range(30000, 36000));
			default: return Q_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [31:0] rand_depth();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			2: return $urandom_range(0, 3);
			default: return sh_dist_start + $urandom_range(0, 4000000) - 32'd500000;
		endcase
	endfunction

	task automatic push_pixel(logic [Q_W-1:0] x, logic [Q_W-1:0] y, logic [31:0] d,
			logic [Q_W-1:0] r);
		pixel_t px;
		px.x = x;
		px.y = y;
		px.depth = d;
		px.rough = r;
		pending_pixels.push_back(px);
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			push_pixel(rand_q(), rand_q(), rand_depth(), rand_q());
		drain();
	endtask

	// Stimulus: directed corners under the reset settings, then random pixels
	// across several register settings, extremes among them.
	initial begin
		sh_edge_on = 1'b1;
		sh_edge_start = 17'd52429;
		sh_edge_end = 17'd65536;
		sh_dist_on = 1'b1;
		sh_dist_start = 32'd3276800;
		sh_dist_end = 32'd6553600;
		sh_rough_thr = 17'd32768;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_pixel('0, '0, '0, '0);
		push_pixel(17'd65536, 17'd65536, 32'hFFFF_FFFF, 17'd65536);
		push_pixel(17'd131071, 17'd131071, 32'd3276800, 17'd131071);
		push_pixel(17'd32768, 17'd32768, 32'd3276801, 17'd32769);
		push_pixel(17'd32768, 17'd65000, 32'd5000000, 17'd40000);
		push_pixel(17'd60000, 17'd32768, 32'd6553600, 17'd32768);
		push_pixel(17'd59000, 17'd10, 32'd6553599, 17'd65535);
		push_pixel(17'd1, 17'd32768, 32'd0, 17'd1);
		drain();

		// An empty span and a threshold at or above 1.0 give zero for values above the start.
		write_reg(CFG_EDGE_START, 32'd40000);
		write_reg(CFG_EDGE_END, 32'd40000);
		write_reg(CFG_DIST_START, 32'd100);
		write_reg(CFG_DIST_END, 32'd50);
		write_reg(CFG_ROUGH_THR, 32'd65536);
		push_pixel(17'd10000, 17'd32768, 32'd200, 17'd65536);
		push_pixel(17'd32768, 17'd32768, 32'd100, 17'd65535);
		push_pixel(17'd0, 17'd32768, 32'd99, 17'd131071);
		random_phase(150);

		// Both optional factors switched off.
		write_reg(CFG_EDGE_ON, 32'd0);
		write_reg(CFG_DIST_ON, 32'd0);
		write_reg(CFG_ROUGH_THR, 32'd0);
		random_phase(200);

		// Widest edge and distance spans with the enables back on.
		write_reg(CFG_EDGE_ON, 32'd1);
		write_reg(CFG_DIST_ON, 32'd1);
		write_reg(CFG_EDGE_START, 32'd0);
		write_reg(CFG_EDGE_END, 32'd131071);
		write_reg(CFG_DIST_START, 32'd0);
		write_reg(CFG_DIST_END, 32'hFFFF_FFFF);
		write_reg(CFG_ROUGH_THR, 32'd131071);
		random_phase(300);

		for (int k = 0; k < 4; k++) begin
			write_reg(CFG_EDGE_START, $urandom_range(0, 65536));
			write_reg(CFG_EDGE_END, $urandom_range(0, 131071));
			write_reg(CFG_DIST_START, $urandom_range(0, 8000000));
			write_reg(CFG_DIST_END, $urandom_range(0, 8000000) + 32'd1000000);
			write_reg(CFG_ROUGH_THR, $urandom_range(0, 65536));
			write_reg(CFG_EDGE_ON, $urandom_range(0, 1));
			write_reg(CFG_DIST_ON, $urandom_range(0, 1));
			random_phase(230);
		end
		stim_done = 1'b1;
	end

	// Input beats are taken at the rising edge, where the handshake is decided;
	// the prediction is queued at that moment.
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			expected_weights.push_back(predict_weight(pending_pixels.pop_front()));
		end
	end

	// Driver: bursts of pixel beats separated by random gaps, changes on the
	// falling edge; a beat that was not taken stays put until accepted.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(in_valid && !in_taken)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					in_valid <= 1'b1;
					pos_x <= pending_pixels[0].x;
					pos_y <= pending_pixels[0].y;
					view_depth <= pending_pixels[0].depth;
					surface_rough <= pending_pixels[0].rough;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern: periodic or random windows of back-pressure whose
	// style is redrawn at random, including stretches with none.
	always @(negedge clk) begin
		stall_phase++;
		if (stall_phase % 300 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= (stall_phase % 7) < 4;
			2: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= (stall_phase % 23) > 15;
		endcase
	end

	// Monitor: result beats are compared in order at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_weights.size() == 0) begin
				report("unexpected fade_weight", fade_weight, '0);
			end else if (fade_weight !== expected_weights[0]) begin
				report("fade_weight", fade_weight, expected_weights.pop_front());
			end else begin
				void'(expected_weights.pop_front());
			end
		end
	end

	initial begin
		wait (stim_done);
		drain();
		if (mismatch_count == 0 && expected_weights.size() == 0) begin
			$display("reflection_fade_weight_unit: match");
		end else begin
			$display("reflection_fade_weight_unit: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("reflection_fade_weight_unit: mismatch");
		$finish;
	end

endmodule
